FILE: sv/cie_pkg.sv
// Package for the compressed instruction executor: item types, codes and byte-order helper.
// No dependencies.
`default_nettype none
package cie_pkg;
	localparam logic [1:0] KIND_INSTR = 2'd0;
	localparam logic [1:0] KIND_MRESP = 2'd1;
	localparam logic [1:0] KIND_RREAD = 2'd2;
	localparam logic [1:0] KIND_RWRITE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;
	localparam logic [1:0] ST_BUSY = 2'd3;

	localparam logic [3:0] OP_RR = 4'h8;
	localparam logic [3:0] OP_IMM = 4'h9;
	localparam logic [3:0] OP_LOAD = 4'hA;
	localparam logic [3:0] OP_STORE = 4'hB;
	localparam logic [3:0] OP_JUMP = 4'hC;

	localparam logic [3:0] FN_ADD = 4'h0;
	localparam logic [3:0] FN_SUB = 4'h1;
	localparam logic [3:0] FN_MUL = 4'h2;
	localparam logic [3:0] FN_AND = 4'h3;
	localparam logic [3:0] FN_OR = 4'h4;
	localparam logic [3:0] FN_XOR = 4'h5;
	localparam logic [3:0] FN_MV = 4'hF;

	localparam logic [3:0] IM_ADD = 4'h0;
	localparam logic [3:0] IM_SUB = 4'h1;
	localparam logic [3:0] IM_AND = 4'h2;
	localparam logic [3:0] IM_OR = 4'h3;
	localparam logic [3:0] IM_XOR = 4'h4;
	localparam logic [3:0] IM_LI = 4'h5;

	localparam logic [1:0] REG_LITTLE_ENDIAN = 2'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [15:0] instruction;
		logic [63:0] pc;
		logic [63:0] mem_data;
		logic mem_error;
		logic [4:0] reg_index;
		logic [63:0] reg_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [63:0] fault_address;
		logic mem_request;
		logic mem_write;
		logic [63:0] mem_address;
		logic [1:0] mem_size_code;
		logic [63:0] mem_write_data;
		logic [63:0] next_pc;
		logic [63:0] read_value;
	} out_item_t;

	// Keep the low 2**code bytes, reversed among themselves when big-endian.
	function automatic logic [63:0] order_bytes(logic [63:0] v, logic [1:0] code,
			logic little);
		logic [63:0] m;
		logic [63:0] r;
		m = v;
		r = '0;
		unique case (code)
			2'd0: m = {56'd0, v[7:0]};
			2'd1: m = {48'd0, v[15:0]};
			2'd2: m = {32'd0, v[31:0]};
			default: m = v;
		endcase
		if (little) begin
			r = m;
		end else begin
			unique case (code)
				2'd0: r = m;
				2'd1: r = {48'd0, m[7:0], m[15:8]};
				2'd2: r = {32'd0, m[7:0], m[15:8], m[23:16], m[31:24]};
				default: r = {m[7:0], m[15:8], m[23:16], m[31:24],
					m[39:32], m[47:40], m[55:48], m[63:56]};
			endcase
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: sv/cie_if.sv
// Valid/ready channel interface carrying one word of a given payload type.
// Does not itself depend on cie_pkg; the payload type comes in as a parameter.
`default_nettype none
interface cie_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/cie_front.sv
// Front end: accepts input words and holds them for the back end.
// Uses cie_pkg; feeds a two-entry queue toward the back end.
`default_nettype none
module cie_front (
	input wire logic clk,
	input wire logic arst_n,
	cie_if.sink in_ch,
	output logic q_valid,
	output cie_pkg::in_item_t q_data,
	input wire logic q_pop
);
	import cie_pkg::*;

	in_item_t buf_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

FILE: sv/cie_back.sv
// Back end: register file, operand read, execute and result register.
// Uses cie_pkg; takes words from the front queue.
`default_nettype none
module cie_back #(
	parameter int REG_COUNT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic little_endian,
	input wire logic q_valid,
	input cie_pkg::in_item_t q_data,
	output logic q_pop,
	cie_if.source out_ch
);
	import cie_pkg::*;

	localparam int IW = (REG_COUNT > 32) ? $clog2(REG_COUNT) : 5;

	logic [63:0] rf_q [REG_COUNT];
	logic [REG_COUNT-1:0] rf_valid_q;

	logic pend_q, pend_store_q;
	logic [4:0] pend_reg_q;
	logic [1:0] pend_size_q;
	logic [63:0] pend_addr_q;

	// Stage 1: operands read, word held.
	logic v_s1;
	in_item_t it_s1;
	logic [63:0] x_s1, y_s1, z_s1;

	// Multiply partial products, formed while mul_wait holds the execute stage.
	logic mul_wait, mul_ok_q;
	logic [63:0] mul_lo_q;
	logic [31:0] mul_mid_q;

	out_item_t res;
	logic wr_en;
	logic [4:0] wr_idx;
	logic [63:0] wr_val;
	logic pend_set, pend_clr;
	logic stall, take_s1;

	function automatic logic [63:0] rd(logic [IW-1:0] a, logic [63:0] v,
			logic [REG_COUNT-1:0] vb);
		logic [63:0] r;
		r = '0;
		if (int'(a) < REG_COUNT && vb[a]) r = v;
		return r;
	endfunction

	logic [IW-1:0] ax, ay, az, ai;
	assign ax = IW'(q_data.instruction[7:4]);
	assign ay = IW'(q_data.instruction[11:8]);
	assign az = IW'({1'b0, q_data.instruction[7:4]} + 5'd1);
	assign ai = IW'(q_data.reg_index);

	assign stall = out_ch.valid && !out_ch.ready;
	// Hold off a new read while stage 1 writes; it would see stale data.
	assign take_s1 = !stall && !mul_wait;
	assign q_pop = q_valid && take_s1 && !(v_s1 && wr_en);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_s1 <= q_data;
			if (q_data.kind == KIND_RREAD) x_s1 <= rd(ai, rf_q[ai], rf_valid_q);
			else x_s1 <= rd(ax, rf_q[ax], rf_valid_q);
			y_s1 <= rd(ay, rf_q[ay], rf_valid_q);
			z_s1 <= rd(az, rf_q[az], rf_valid_q);
		end
		if (mul_wait) begin
			mul_lo_q <= {32'd0, x_s1[31:0]} * {32'd0, y_s1[31:0]};
			mul_mid_q <= x_s1[31:0] * y_s1[63:32] + x_s1[63:32] * y_s1[31:0];
		end
		if (wr_en && int'(wr_idx) < REG_COUNT) rf_q[IW'(wr_idx)] <= wr_val;
	end

	logic [3:0] op, b, r, f;
	logic [63:0] imm, off;
	logic [1:0] code;
	assign op = it_s1.instruction[15:12];
	assign b = it_s1.instruction[11:8];
	assign r = it_s1.instruction[7:4];
	assign f = it_s1.instruction[3:0];
	assign imm = {56'd0, b, f};
	assign code = 2'd3 - f[1:0];
	assign off = {{52{it_s1.instruction[11]}}, it_s1.instruction[11:0]};

	assign mul_wait = v_s1 && !mul_ok_q && it_s1.kind == KIND_INSTR && !pend_q
		&& op == OP_RR && f == FN_MUL;

	always_comb begin
		res = '0;
		wr_en = 1'b0;
		wr_idx = {1'b0, r};
		wr_val = '0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		unique case (it_s1.kind)
			KIND_INSTR: begin
				res.next_pc = it_s1.pc;
				if (pend_q) begin
					res.status = ST_BUSY;
				end else begin
					unique case (op)
						OP_RR: begin
							wr_en = 1'b1;
							case (f)
								FN_ADD: wr_val = x_s1 + y_s1;
								FN_SUB: wr_val = x_s1 - y_s1;
								FN_MUL: wr_val = mul_lo_q + {mul_mid_q, 32'd0};
								FN_AND: wr_val = x_s1 & y_s1;
								FN_OR: wr_val = x_s1 | y_s1;
								FN_XOR: wr_val = x_s1 ^ y_s1;
								FN_MV: wr_val = y_s1;
								default: begin
									wr_en = 1'b0;
									res.status = ST_INVALID;
								end
							endcase
						end
						OP_IMM: begin
							wr_en = 1'b1;
							case (b)
								IM_ADD: wr_val = x_s1 + imm;
								IM_SUB: wr_val = x_s1 - imm;
								IM_AND: wr_val = x_s1 & imm;
								IM_OR: wr_val = x_s1 | imm;
								IM_XOR: wr_val = x_s1 ^ imm;
								IM_LI: wr_val = imm;
								default: begin
									wr_en = 1'b0;
									res.status = ST_INVALID;
								end
							endcase
						end
						OP_LOAD, OP_STORE: begin
							if (f[3:2] != 2'd0) begin
								res.status = ST_INVALID;
							end else begin
								pend_set = 1'b1;
								res.mem_request = 1'b1;
								res.mem_write = (op == OP_STORE);
								res.mem_address = x_s1 + ({60'd0, b} << code);
								res.mem_size_code = code;
								if (op == OP_STORE)
									res.mem_write_data = order_bytes(z_s1, code,
										little_endian);
							end
						end
						OP_JUMP: res.next_pc = it_s1.pc + (off << 1) - 64'd2;
						default: res.status = ST_INVALID;
					endcase
				end
			end
			KIND_MRESP: begin
				if (pend_q) begin
					pend_clr = 1'b1;
					if (it_s1.mem_error) begin
						res.status = ST_FAULT;
						res.fault_address = pend_addr_q;
					end else if (!pend_store_q) begin
						wr_en = 1'b1;
						wr_idx = pend_reg_q;
						wr_val = order_bytes(it_s1.mem_data, pend_size_q, little_endian);
					end
				end
			end
			KIND_RREAD: res.read_value = x_s1;
			default: begin
				wr_en = 1'b1;
				wr_idx = it_s1.reg_index;
				wr_val = it_s1.reg_value;
			end
		endcase
		if (!v_s1 || stall || mul_wait) begin
			wr_en = 1'b0;
			pend_set = 1'b0;
			pend_clr = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !stall && !mul_wait) out_ch.data <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_ch.valid <= 1'b0;
			mul_ok_q <= 1'b0;
			rf_valid_q <= '0;
			pend_q <= 1'b0;
			pend_store_q <= 1'b0;
			pend_reg_q <= '0;
			pend_size_q <= '0;
			pend_addr_q <= '0;
		end else begin
			if (!stall) begin
				if (mul_wait) begin
					out_ch.valid <= 1'b0;
				end else begin
					out_ch.valid <= v_s1;
					v_s1 <= q_pop;
				end
			end
			mul_ok_q <= mul_wait || (mul_ok_q && stall);
			if (wr_en && int'(wr_idx) < REG_COUNT) rf_valid_q[IW'(wr_idx)] <= 1'b1;
			if (pend_set) begin
				pend_q <= 1'b1;
				pend_store_q <= (op == OP_STORE);
				pend_reg_q <= {1'b0, r};
				pend_size_q <= code;
				pend_addr_q <= res.mem_address;
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/compressed_instruction_executor_core.sv
// Compressed instruction executor: one result word per input word.
// A word passes the front queue, the stage 1 register and the output register. One word
// per cycle while the output is not stalled, except a word right behind one that writes
// the register file waits for the write-back, so register writes are not taken back to back.
// A multiply holds the execute stage while it forms its partial products, then combines them.
// arst_n clears control state, the register file valid bits and the pending access.
`default_nettype none
module compressed_instruction_executor_core #(
	parameter int REG_COUNT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	cie_if.sink in_ch,
	cie_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cie_pkg::*;

	logic little_endian_q;
	logic q_valid, q_pop;
	in_item_t q_data;

	assign pready = 1'b1;
	assign prdata = (paddr == {REG_LITTLE_ENDIAN}) ? {31'd0, little_endian_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_endian_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == REG_LITTLE_ENDIAN) begin
			little_endian_q <= pwdata[0];
		end
	end

	cie_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	cie_back #(.REG_COUNT(REG_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .little_endian(little_endian_q),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
